### sv/kset_pkg.sv
// Shared types and codes for the keyed set with compaction.
`timescale 1ns / 1ps

package kset_pkg;

    localparam int KEY_W         = 44;
    localparam int YEAR_W        = 14;
    localparam int GENDER_W      = 8;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [YEAR_W-1:0]   birth_year;
        logic [GENDER_W-1:0] gender;
    } kset_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } kset_res_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [YEAR_W-1:0]   year;
        logic [GENDER_W-1:0] gender;
    } kset_rec_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic append;
        logic remove;
    } kset_cell_ctrl_t;

endpackage

### sv/kset_cell.sv
// One slot of the set: holds a record, compares keys and shifts down on removal.
`timescale 1ns / 1ps

module kset_cell (
    input  logic                     aclk,
    input  kset_pkg::kset_cell_ctrl_t ctrl,
    input  logic                     occupied,
    input  logic [kset_pkg::KEY_W-1:0] key_in,
    input  kset_pkg::kset_rec_t      new_rec,
    input  kset_pkg::kset_rec_t      next_rec,
    input  logic                     match_in,
    output kset_pkg::kset_rec_t      rec_out,
    output logic                     match_out
);
    import kset_pkg::*;

    kset_rec_t rec_reg;
    logic      hit;

    assign hit       = occupied && (rec_reg.key == key_in);
    assign match_out = match_in | hit;
    assign rec_out   = rec_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.append) begin
            rec_reg <= new_rec;
        end else if (ctrl.remove && match_out) begin
            // take the neighbour's record from the removed slot onwards
            rec_reg <= next_rec;
        end
    end

endmodule

### sv/keyed_set_insert_remove.sv
// Top level of the keyed set: a row of record cells with count and result register.
// The result is registered and becomes valid in the cycle after a request is accepted.
// Throughput: one request per cycle unless a held result stalls on a low m_ready; the key compare ripples
// along the row of cells and the removal shift happens in that same cycle.
// Reset: aresetn (synchronous, active low) clears the entry count and result valid;
// record contents stay undefined until written.
`timescale 1ns / 1ps

module keyed_set_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kset_pkg::kset_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output kset_pkg::kset_res_t m_res
);
    import kset_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    kset_res_t        m_res_reg;

    logic            accept;
    logic            found;
    logic            is_full;
    logic            is_empty;
    logic            do_add;
    logic            do_remove;
    status_t         status;
    kset_rec_t       new_rec;
    kset_rec_t       recs  [CAPACITY];
    logic            match [CAPACITY+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    assign new_rec.key    = s_req.key;
    assign new_rec.year   = s_req.birth_year;
    assign new_rec.gender = s_req.gender;

    assign match[0] = 1'b0;
    assign found    = match[CAPACITY];
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        do_add     = 1'b0;
        do_remove  = 1'b0;
        count_next = count_reg;
        if (s_req.op == OP_ADD) begin
            if (found) begin
                status = ST_DUPLICATE;
            end else if (is_full) begin
                status = ST_FULL;
            end else begin
                status     = ST_ADDED;
                do_add     = accept;
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                status = ST_EMPTY;
            end else if (!found) begin
                status = ST_NOT_FOUND;
            end else begin
                status     = ST_REMOVED;
                do_remove  = accept;
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        kset_cell_ctrl_t ctrl;
        kset_rec_t       next_rec;

        assign ctrl.append = do_add && (count_reg == CNT_W'(i));
        assign ctrl.remove = do_remove;

        if (i == CAPACITY - 1) begin : g_last
            // last slot falls out of the count on removal: hold it
            assign next_rec = recs[i];
        end else begin : g_mid
            assign next_rec = recs[i+1];
        end

        kset_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (CNT_W'(i) < count_reg),
            .key_in    (s_req.key),
            .new_rec   (new_rec),
            .next_rec  (next_rec),
            .match_in  (match[i]),
            .rec_out   (recs[i]),
            .match_out (match[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg             <= count_next;
                m_valid_reg           <= 1'b1;
                m_res_reg.status      <= status;
                m_res_reg.entry_count <= ENTRY_COUNT_W'(count_next);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
